### src/cdn_pkg.sv
`default_nettype none

package cdn_pkg;

    localparam int NUM_STAGES = 16;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MONTH = 3'd1,
        ST_DAY_LOW   = 3'd2,
        ST_DAY_HIGH  = 3'd3,
        ST_YEAR_LOW  = 3'd4,
        ST_RANGE     = 3'd5
    } status_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;
        logic                  in_ready;
        logic                  out_valid;
    } pipe_ctl_t;

    localparam logic [13:0] MIN_YEAR        = 14'd1583;
    localparam logic [22:0] REFORM_DAY      = 23'd2299161;
    localparam logic [22:0] LAST_DAY_NUMBER = 23'd5373484;
    localparam logic [10:0] DAYS_PER_4Y     = 11'd1461;
    localparam logic [12:0] YEAR_OFS        = 13'd4716;
    localparam logic [12:0] YEAR_OFS_JF     = 13'd4715;
    localparam logic [10:0] JDN_BIAS        = 11'd1522;
    localparam logic [12:0] DIV100_MUL      = 13'd5243;
    localparam logic [6:0]  HUNDRED         = 7'd100;
    localparam logic [22:0] ALPHA_BIAS      = 23'd7468865;
    localparam logic [17:0] ALPHA_DIV       = 18'd146097;
    localparam logic [6:0]  ALPHA_MUL       = 7'd114;
    localparam logic [20:0] WD_MUL          = 21'd1198372;
    localparam logic [2:0]  WD_DIV          = 3'd7;
    localparam logic [10:0] BB_BIAS         = 11'd1524;
    localparam logic [14:0] NUMC_BIAS       = 15'd28038;
    localparam logic [14:0] CC_MUL          = 15'd18373;
    localparam logic [12:0] CC_DIV          = 13'd7305;
    localparam logic [8:0]  WEEK_MUL        = 9'd293;

    // floor(30.6001 * e)
    function automatic logic [8:0] month_term(input logic [4:0] e);
        logic [8:0] r;
        unique case (e)
            5'd1:    r = 9'd30;
            5'd2:    r = 9'd61;
            5'd3:    r = 9'd91;
            5'd4:    r = 9'd122;
            5'd5:    r = 9'd153;
            5'd6:    r = 9'd183;
            5'd7:    r = 9'd214;
            5'd8:    r = 9'd244;
            5'd9:    r = 9'd275;
            5'd10:   r = 9'd306;
            5'd11:   r = 9'd336;
            5'd12:   r = 9'd367;
            5'd13:   r = 9'd397;
            5'd14:   r = 9'd428;
            5'd15:   r = 9'd459;
            5'd16:   r = 9'd489;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // floor(275 * m / 9)
    function automatic logic [8:0] year_day_base(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd30;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd91;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd152;
            4'd6:    r = 9'd183;
            4'd7:    r = 9'd213;
            4'd8:    r = 9'd244;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd305;
            4'd11:   r = 9'd336;
            4'd12:   r = 9'd366;
            4'd13:   r = 9'd397;
            4'd14:   r = 9'd427;
            4'd15:   r = 9'd458;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // floor((m + 9) / 12)
    function automatic logic [1:0] year_fix(input logic [3:0] m);
        logic [1:0] r;
        if (m < 4'd3) begin
            r = 2'd0;
        end else if (m == 4'd15) begin
            r = 2'd2;
        end else begin
            r = 2'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/cdn_pipe_ctrl.sv
`default_nettype none

module cdn_pipe_ctrl
    import cdn_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    input  wire logic  out_ready,
    output pipe_ctl_t  ctl
);

    localparam int LAST = NUM_STAGES - 1;

    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] free;

    // a stage loads when it is empty or its word moves on; bubbles collapse
    always_comb begin
        free[LAST] = !v_reg[LAST] || out_ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            free[i] = !v_reg[i] || free[i+1];
        end
        v_next[0] = free[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            v_next[i] = free[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign ctl.ld        = free;
    assign ctl.in_ready  = free[0];
    assign ctl.out_valid = v_reg[LAST];

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctl.in_ready |-> (&v_reg))
        else $error("input blocked while a stage is empty");

    a_word_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            $countones(v_reg) == $past($countones(v_reg))
                + int'($past(in_valid && free[0]))
                - int'($past(v_reg[LAST] && out_ready)))
        else $error("word lost or duplicated in pipeline");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (v_reg == '0))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

### src/calendar_date_day_number_engine.sv
// Calendar date day-number engine.
// Input channel (s_valid/s_ready): one word holds a Gregorian date
// (s_in_day, s_in_month, s_in_year) and a signed day offset.
// Output channel (m_valid/m_ready): one result word per input word, in
// order: status, shifted Julian day number, calendar date of that day
// (Julian calendar before 15 Oct 1582), weekday, day and week of year,
// leap flag. With a nonzero status all other result fields are zero.
// Throughput is one word per cycle while s_ready is high. The depth comes
// from the chain of constant divisions, each a reciprocal multiply; those
// for alpha, weekday and cc add a back-multiply and one correction step.
// Reset (aresetn low, synchronous) empties the pipeline; nothing else is
// held across words.
// When m_ready is low the last stage holds its word and earlier stages keep
// filling empty slots; s_ready drops only when all 16 stages are full.

`default_nettype none

module calendar_date_day_number_engine
    import cdn_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic        [4:0]  s_in_day,
    input  wire logic        [3:0]  s_in_month,
    input  wire logic        [13:0] s_in_year,
    input  wire logic signed [20:0] s_offset_days,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic             [2:0]  m_status,
    output logic             [22:0] m_day_number,
    output logic             [4:0]  m_out_day,
    output logic             [3:0]  m_out_month,
    output logic signed      [14:0] m_out_year,
    output logic             [2:0]  m_weekday,
    output logic             [8:0]  m_year_day,
    output logic             [5:0]  m_year_week,
    output logic                    m_leap
);

    typedef struct packed {
        status_t     status;
        logic [22:0] n;
        logic        jul;
        logic [2:0]  wd;
    } carry_t;

    pipe_ctl_t ctl;

    cdn_pipe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .out_ready (m_ready),
        .ctl       (ctl)
    );

    assign s_ready = ctl.in_ready;
    assign m_valid = ctl.out_valid;

    carry_t c_reg  [NUM_STAGES];
    carry_t c_next [NUM_STAGES];

    // stage 1: split date, forward products
    logic        [4:0]  d1_reg;
    logic        [3:0]  m1_reg;
    logic        [13:0] y1_reg;
    logic signed [20:0] off1_reg;
    logic               mbad1_reg, dzero1_reg;
    logic        [22:0] t1_reg, t1_next;
    logic        [8:0]  mt1_reg, mt1_next;
    logic        [7:0]  a1_reg, a1_next;
    logic        [7:0]  qy1_reg, qy1_next;
    logic        [13:0] yy1;
    logic        [3:0]  mm1;
    logic        [24:0] t1_prod;
    logic        [26:0] a1_prod, qy1_prod;

    assign yy1      = (s_in_month <= 4'd2) ? s_in_year - 14'd1 : s_in_year;
    assign mm1      = (s_in_month <= 4'd2) ? s_in_month + 4'd12 : s_in_month;
    assign t1_prod  = 25'(15'(yy1) + 15'(YEAR_OFS)) * 25'(DAYS_PER_4Y);
    assign t1_next  = t1_prod[24:2];
    assign mt1_next = month_term(5'(mm1) + 5'd1);
    assign a1_prod  = 27'(yy1) * 27'(DIV100_MUL);
    assign a1_next  = a1_prod[26:19];
    assign qy1_prod = 27'(s_in_year) * 27'(DIV100_MUL);
    assign qy1_next = qy1_prod[26:19];

    // stage 2: validation, day number
    logic        [22:0] jdn2_reg, jdn2_next;
    logic signed [20:0] off2_reg;
    logic        [13:0] rem2;
    logic               leap2;
    logic        [4:0]  mlen2;
    logic        [23:0] jdn2_sum;
    status_t            st2;

    assign rem2  = y1_reg - 14'(15'(qy1_reg) * 15'(HUNDRED));
    assign leap2 = (y1_reg[1:0] == 2'd0) && ((rem2 != 14'd0) || (qy1_reg[1:0] == 2'd0));

    always_comb begin
        unique case (m1_reg) inside
            4'd2:                    mlen2 = 5'd28 + 5'(leap2);
            4'd4, 4'd6, 4'd9, 4'd11: mlen2 = 5'd30;
            default:                 mlen2 = 5'd31;
        endcase
        if (mbad1_reg) begin
            st2 = ST_BAD_MONTH;
        end else if (dzero1_reg) begin
            st2 = ST_DAY_LOW;
        end else if (d1_reg > mlen2) begin
            st2 = ST_DAY_HIGH;
        end else if (y1_reg < MIN_YEAR) begin
            st2 = ST_YEAR_LOW;
        end else begin
            st2 = ST_OK;
        end
    end

    assign jdn2_sum  = {1'b0, t1_reg} + 24'(mt1_reg) + 24'(d1_reg) + 24'(a1_reg[7:2])
                     - 24'(a1_reg) - 24'(JDN_BIAS);
    assign jdn2_next = jdn2_sum[22:0];

    // stage 3: add offset, range check
    logic signed [24:0] n3_sum;
    logic               oor3;

    assign n3_sum = $signed({2'b00, jdn2_reg}) + 25'(off2_reg);
    assign oor3   = n3_sum[24] || (n3_sum[23:0] > 24'(LAST_DAY_NUMBER));

    // stage 4: alpha and weekday reciprocal products
    logic [23:0] num4_reg;
    logic [6:0]  alpha4_reg;
    logic [22:0] x7_4_reg, x7_4_next;
    logic [20:0] q7_4_reg;
    logic [24:0] num4_full;
    logic [30:0] p_alpha4;
    logic [43:0] p_wd4;

    assign num4_full = {c_reg[2].n, 2'b00} - 25'(ALPHA_BIAS);
    assign p_alpha4  = 31'(num4_full[23:0]) * 31'(ALPHA_MUL);
    assign x7_4_next = c_reg[2].n + 23'd1;
    assign p_wd4     = 44'(x7_4_next) * 44'(WD_MUL);

    // stage 5: remainders
    logic [6:0]  alpha5_reg;
    logic [18:0] ra5_reg;
    logic [3:0]  r7_5_reg;
    logic [23:0] ra5_full;
    logic [23:0] r7_5_full;

    assign ra5_full  = num4_reg - 24'(25'(alpha4_reg) * 25'(ALPHA_DIV));
    assign r7_5_full = 24'(x7_4_reg) - 24'(q7_4_reg) * 24'(WD_DIV);

    // stage 6: corrected alpha, aa
    logic [22:0] aa6_reg, aa6_next;
    logic [6:0]  alpha6;
    logic [2:0]  wd6;

    assign alpha6   = alpha5_reg + 7'(ra5_reg >= 19'(ALPHA_DIV));
    assign aa6_next = c_reg[4].jul ? c_reg[4].n
                    : c_reg[4].n + 23'd1 + 23'(alpha6) - 23'(alpha6[6:2]);
    assign wd6      = (r7_5_reg >= 4'(WD_DIV)) ? 3'(r7_5_reg - 4'(WD_DIV)) : r7_5_reg[2:0];

    // stage 7..10: cc = (20 * bb - 2442) / 7305
    logic [22:0] bb7_reg, bb8_reg, bb9_reg, bb10_reg;
    logic [26:0] numc7_reg, numc8_reg;
    logic [14:0] cc8_reg, cc9_reg, cc10_reg, cc11_reg, cc12_reg;
    logic [13:0] rc9_reg;
    logic [26:0] numc7_next;
    logic [41:0] p_cc8;
    logic [26:0] rc9_full;

    assign numc7_next = 27'({aa6_reg, 4'b0000}) + 27'({aa6_reg, 2'b00}) + 27'(NUMC_BIAS);
    assign p_cc8      = 42'(numc7_reg) * 42'(CC_MUL);
    assign rc9_full   = numc8_reg - 27'(cc8_reg) * 27'(CC_DIV);

    // stage 11: days left in the year cycle
    logic [9:0]  x11_reg, x12_reg;
    logic [25:0] dd11_prod;
    logic [23:0] x11_full;

    assign dd11_prod = 26'(cc10_reg) * 26'(DAYS_PER_4Y);
    assign x11_full  = 24'(bb10_reg) - dd11_prod[25:2];

    // stage 12: month index by threshold compare
    logic [4:0] ee12_reg, ee12_next;

    always_comb begin
        ee12_next = 5'd0;
        for (int e = 1; e <= 16; e++) begin
            ee12_next = ee12_next + 5'(x11_reg > 10'(month_term(5'(e))));
        end
    end

    // stage 13: day, month, year
    logic        [4:0]  rd13_reg, rd14_reg, rd15_reg;
    logic        [3:0]  rm13_reg, rm14_reg, rm15_reg, rm13_next;
    logic signed [14:0] ry13_reg, ry14_reg, ry15_reg;
    logic        [9:0]  rd13_full;
    logic signed [15:0] ry13_wide;

    assign rd13_full = x12_reg - 10'(month_term(ee12_reg));
    assign rm13_next = (ee12_reg < 5'd14) ? 4'(ee12_reg - 5'd1) : 4'(ee12_reg - 5'd13);
    assign ry13_wide = $signed({1'b0, cc12_reg})
                     - $signed({3'b000, (rm13_next > 4'd2) ? YEAR_OFS : YEAR_OFS_JF});

    // stage 14: century quotient, day of year base
    logic [7:0]  q100_14_reg;
    logic [9:0]  ydb14_reg, ydb14_next;
    logic [1:0]  fix14_reg;
    logic [26:0] p100_14;

    assign p100_14    = 27'(ry13_reg[13:0]) * 27'(DIV100_MUL);
    assign ydb14_next = 10'(year_day_base(rm13_reg)) + 10'(rd13_reg) - 10'd30
                      - 10'({year_fix(rm13_reg), 1'b0});

    // stage 15: leap flag, day of year
    logic [8:0]  yd15_reg;
    logic        leap15_reg;
    logic [13:0] r100_15;
    logic        leap15_next;

    assign r100_15     = ry14_reg[13:0] - 14'(15'(q100_14_reg) * 15'(HUNDRED));
    assign leap15_next = c_reg[13].jul ? (ry14_reg[1:0] == 2'd0)
                       : (ry14_reg[1:0] == 2'd0)
                         && ((r100_15 != 14'd0) || (q100_14_reg[1:0] == 2'd0));

    // stage 16: week, output register
    logic        [2:0]  o_status_reg;
    logic        [22:0] o_day_number_reg;
    logic        [4:0]  o_day_reg;
    logic        [3:0]  o_month_reg;
    logic signed [14:0] o_year_reg;
    logic        [2:0]  o_weekday_reg;
    logic        [8:0]  o_year_day_reg;
    logic        [5:0]  o_year_week_reg;
    logic               o_leap_reg;
    logic        [17:0] p_week16;
    logic        [5:0]  yw16;
    logic               ok16;

    assign p_week16 = 18'(yd15_reg) * 18'(WEEK_MUL);
    assign yw16     = 6'(p_week16[17:11]) + 6'd1;
    assign ok16     = (c_reg[14].status == ST_OK);

    always_comb begin
        c_next[0].status = ST_OK;
        c_next[0].n      = '0;
        c_next[0].jul    = 1'b0;
        c_next[0].wd     = '0;
        for (int i = 1; i < NUM_STAGES; i++) begin
            c_next[i] = c_reg[i-1];
        end
        c_next[1].status = st2;
        c_next[2].n      = n3_sum[22:0];
        if ((c_reg[1].status == ST_OK) && oor3) begin
            c_next[2].status = ST_RANGE;
        end
        c_next[3].jul = (c_reg[2].n < REFORM_DAY);
        c_next[5].wd  = wd6;
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_STAGES; i++) begin
            if (ctl.ld[i]) begin
                c_reg[i] <= c_next[i];
            end
        end
        if (ctl.ld[0]) begin
            d1_reg     <= s_in_day;
            m1_reg     <= s_in_month;
            y1_reg     <= s_in_year;
            off1_reg   <= s_offset_days;
            mbad1_reg  <= (s_in_month < 4'd1) || (s_in_month > 4'd12);
            dzero1_reg <= (s_in_day == 5'd0);
            t1_reg     <= t1_next;
            mt1_reg    <= mt1_next;
            a1_reg     <= a1_next;
            qy1_reg    <= qy1_next;
        end
        if (ctl.ld[1]) begin
            jdn2_reg <= jdn2_next;
            off2_reg <= off1_reg;
        end
        if (ctl.ld[3]) begin
            num4_reg   <= num4_full[23:0];
            alpha4_reg <= p_alpha4[30:24];
            x7_4_reg   <= x7_4_next;
            q7_4_reg   <= p_wd4[43:23];
        end
        if (ctl.ld[4]) begin
            alpha5_reg <= alpha4_reg;
            ra5_reg    <= ra5_full[18:0];
            r7_5_reg   <= r7_5_full[3:0];
        end
        if (ctl.ld[5]) begin
            aa6_reg <= aa6_next;
        end
        if (ctl.ld[6]) begin
            bb7_reg   <= aa6_reg + 23'(BB_BIAS);
            numc7_reg <= numc7_next;
        end
        if (ctl.ld[7]) begin
            bb8_reg   <= bb7_reg;
            numc8_reg <= numc7_reg;
            cc8_reg   <= p_cc8[41:27];
        end
        if (ctl.ld[8]) begin
            bb9_reg <= bb8_reg;
            cc9_reg <= cc8_reg;
            rc9_reg <= rc9_full[13:0];
        end
        if (ctl.ld[9]) begin
            bb10_reg <= bb9_reg;
            cc10_reg <= cc9_reg + 15'(rc9_reg >= 14'(CC_DIV));
        end
        if (ctl.ld[10]) begin
            cc11_reg <= cc10_reg;
            x11_reg  <= x11_full[9:0];
        end
        if (ctl.ld[11]) begin
            cc12_reg <= cc11_reg;
            x12_reg  <= x11_reg;
            ee12_reg <= ee12_next;
        end
        if (ctl.ld[12]) begin
            rd13_reg <= rd13_full[4:0];
            rm13_reg <= rm13_next;
            ry13_reg <= ry13_wide[14:0];
        end
        if (ctl.ld[13]) begin
            rd14_reg    <= rd13_reg;
            rm14_reg    <= rm13_reg;
            ry14_reg    <= ry13_reg;
            q100_14_reg <= p100_14[26:19];
            ydb14_reg   <= ydb14_next;
            fix14_reg   <= year_fix(rm13_reg);
        end
        if (ctl.ld[14]) begin
            rd15_reg   <= rd14_reg;
            rm15_reg   <= rm14_reg;
            ry15_reg   <= ry14_reg;
            leap15_reg <= leap15_next;
            yd15_reg   <= 9'(ydb14_reg + (leap15_next ? 10'(fix14_reg) : 10'd0));
        end
        if (ctl.ld[15]) begin
            o_status_reg     <= c_reg[14].status;
            o_day_number_reg <= ok16 ? c_reg[14].n : '0;
            o_day_reg        <= ok16 ? rd15_reg : '0;
            o_month_reg      <= ok16 ? rm15_reg : '0;
            o_year_reg       <= ok16 ? ry15_reg : '0;
            o_weekday_reg    <= ok16 ? c_reg[14].wd : '0;
            o_year_day_reg   <= ok16 ? yd15_reg : '0;
            o_year_week_reg  <= ok16 ? yw16 : '0;
            o_leap_reg       <= ok16 && leap15_reg;
        end
    end

    assign m_status     = o_status_reg;
    assign m_day_number = o_day_number_reg;
    assign m_out_day    = o_day_reg;
    assign m_out_month  = o_month_reg;
    assign m_out_year   = o_year_reg;
    assign m_weekday    = o_weekday_reg;
    assign m_year_day   = o_year_day_reg;
    assign m_year_week  = o_year_week_reg;
    assign m_leap       = o_leap_reg;

endmodule

`default_nettype wire
